@@ rtl/trace_coordinate_scale_and_offset_top_defines.svh @@
// assertion macros shared by the checker
`ifndef TRACE_COORDINATE_SCALE_AND_OFFSET_TOP_DEFINES_SVH
`define TRACE_COORDINATE_SCALE_AND_OFFSET_TOP_DEFINES_SVH

// condition implies consequence in the same cycle
`define TCSO_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define TCSO_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ rtl/tcso_pkg.sv @@
package tcso_pkg;

  localparam int DATA_W    = 32;
  localparam int SCALAR_W  = 16;
  localparam int LANES     = 6;
  localparam int DIV_STEPS = DATA_W;
  localparam int SUM_W     = 2 * DATA_W - 1;
  localparam int ROOT_STEPS = DATA_W;
  localparam int IDX_W     = 2;

  // lane order of the six header values
  localparam int LANE_SX = 0;
  localparam int LANE_SY = 1;
  localparam int LANE_SE = 2;
  localparam int LANE_RX = 3;
  localparam int LANE_RY = 4;
  localparam int LANE_RE = 5;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COORD_SCALAR = 2'd0;
  localparam logic [IDX_W-1:0] REG_ELEV_SCALAR  = 2'd1;

  typedef logic [LANES-1:0][DATA_W-1:0] coord_t;

  typedef struct packed {
    logic                neg;
    logic [DATA_W-1:0]   num;
    logic [SCALAR_W-1:0] rem;
  } div_lane_t;

  typedef div_lane_t [LANES-1:0] div_word_t;

  typedef struct packed {
    logic             neg;
    logic             sat;
    coord_t           vals;
    logic [SUM_W-1:0] n;
    logic [SUM_W-1:0] res;
  } sqrt_word_t;

endpackage

@@ rtl/tcso_div_cell.sv @@
module tcso_div_cell
  import tcso_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SCALAR_W-1:0] coord_div,
  input  logic [SCALAR_W-1:0] elev_div,
  input  logic                in_valid,
  output logic                in_ready,
  input  div_word_t           in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output div_word_t           out_data
);

  logic                valid_r, valid_nxt;
  div_word_t           data_r, data_nxt;
  logic [SCALAR_W-1:0] dv [LANES];
  logic [SCALAR_W-1:0] sh [LANES];
  logic                ge [LANES];

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // one restoring division step per lane
  always_comb begin
    data_nxt = in_data;
    for (int i = 0; i < LANES; i++) begin
      dv[i] = (i == LANE_SE || i == LANE_RE) ? elev_div : coord_div;
      sh[i] = {in_data[i].rem[SCALAR_W-2:0], in_data[i].num[DATA_W-1]};
      ge[i] = (sh[i] >= dv[i]);
      data_nxt[i].rem = ge[i] ? (sh[i] - dv[i]) : sh[i];
      data_nxt[i].num = {in_data[i].num[DATA_W-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/tcso_mid.sv @@
module tcso_mid
  import tcso_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  div_word_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sqrt_word_t out_data
);

  // stage f: signed quotients
  logic   f_valid_r, f_ready;
  coord_t f_vals_r, f_vals_nxt;
  // stage d: differences
  logic               d_valid_r, d_ready;
  coord_t             d_vals_r;
  logic               d_neg_r, d_neg_nxt, d_sat_r, d_sat_nxt;
  logic [DATA_W-2:0]  d_ax_r, d_ay_r;
  logic [DATA_W:0]    dx, dy, ax, ay;
  // stage m: squares
  logic                m_valid_r, m_ready;
  coord_t              m_vals_r;
  logic                m_neg_r, m_sat_r;
  logic [SUM_W-2:0]    m_sqx_r, m_sqy_r;
  // stage s: sum of squares
  logic       s_valid_r, s_ready;
  sqrt_word_t s_data_r, s_data_nxt;

  assign s_ready  = !s_valid_r || out_ready;
  assign m_ready  = !m_valid_r || s_ready;
  assign d_ready  = !d_valid_r || m_ready;
  assign f_ready  = !f_valid_r || d_ready;
  assign in_ready = f_ready;

  // restore sign of the quotients
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      f_vals_nxt[i] = in_data[i].neg ? (~in_data[i].num + 1'b1) : in_data[i].num;
    end
  end

  // horizontal differences and their magnitudes
  always_comb begin
    dx = {f_vals_r[LANE_SX][DATA_W-1], f_vals_r[LANE_SX]}
       - {f_vals_r[LANE_RX][DATA_W-1], f_vals_r[LANE_RX]};
    dy = {f_vals_r[LANE_SY][DATA_W-1], f_vals_r[LANE_SY]}
       - {f_vals_r[LANE_RY][DATA_W-1], f_vals_r[LANE_RY]};
    ax = dx[DATA_W] ? (~dx + 1'b1) : dx;
    ay = dy[DATA_W] ? (~dy + 1'b1) : dy;
    d_neg_nxt = dx[DATA_W];
    d_sat_nxt = (ax[DATA_W:DATA_W-1] != 2'b00) || (ay[DATA_W:DATA_W-1] != 2'b00);
  end

  // sum of squares feeds the root chain
  always_comb begin
    s_data_nxt.neg  = m_neg_r;
    s_data_nxt.sat  = m_sat_r;
    s_data_nxt.vals = m_vals_r;
    s_data_nxt.n    = {1'b0, m_sqx_r} + {1'b0, m_sqy_r};
    s_data_nxt.res  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
      d_valid_r <= 1'b0;
      m_valid_r <= 1'b0;
      s_valid_r <= 1'b0;
    end else begin
      if (f_ready) f_valid_r <= in_valid;
      if (d_ready) d_valid_r <= f_valid_r;
      if (m_ready) m_valid_r <= d_valid_r;
      if (s_ready) s_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && in_valid) begin
      f_vals_r <= f_vals_nxt;
    end
    if (d_ready && f_valid_r) begin
      d_vals_r <= f_vals_r;
      d_neg_r  <= d_neg_nxt;
      d_sat_r  <= d_sat_nxt;
      d_ax_r   <= ax[DATA_W-2:0];
      d_ay_r   <= ay[DATA_W-2:0];
    end
    if (m_ready && d_valid_r) begin
      m_vals_r <= d_vals_r;
      m_neg_r  <= d_neg_r;
      m_sat_r  <= d_sat_r;
      m_sqx_r  <= d_ax_r * d_ax_r;
      m_sqy_r  <= d_ay_r * d_ay_r;
    end
    if (s_ready && m_valid_r) begin
      s_data_r <= s_data_nxt;
    end
  end

  assign out_valid = s_valid_r;
  assign out_data  = s_data_r;

endmodule

@@ rtl/tcso_sqrt_cell.sv @@
module tcso_sqrt_cell
  import tcso_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sqrt_word_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sqrt_word_t out_data
);

  localparam int             SHIFT = SUM_W - 1 - 2 * STEP;
  localparam logic [SUM_W:0] BIT   = {{SUM_W{1'b0}}, 1'b1} << SHIFT;

  logic           valid_r, valid_nxt;
  sqrt_word_t     data_r, data_nxt;
  logic [SUM_W:0] trial, n_ext, n_sub, res_next;
  logic           take;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  // one digit of the floor root
  always_comb begin
    trial    = {1'b0, in_data.res} + BIT;
    n_ext    = {1'b0, in_data.n};
    take     = (n_ext >= trial);
    n_sub    = n_ext - trial;
    res_next = ({1'b0, in_data.res} >> 1) + BIT;
    data_nxt = in_data;
    data_nxt.n   = take ? n_sub[SUM_W-1:0] : in_data.n;
    data_nxt.res = take ? res_next[SUM_W-1:0] : (in_data.res >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/trace_coordinate_scale_and_offset_top.sv @@
// channel   direction  ports
// in_       input      in_valid/in_ready, six raw header values
// out_      output     out_valid/out_ready, six scaled values, out_signed_offset
// cfg_      input      cfg_valid/cfg_ready, cfg_index, cfg_data (always ready)
//
// one header per cycle sustained while out_ready is high; the path runs through 32 division cells,
// four arithmetic stages, 32 root cells and the output register
// each cell holds a valid bit and hands on when the next one has room
// reset (rst_n low, synchronous) empties the pipeline, scalars return to 1
module trace_coordinate_scale_and_offset_top
  import tcso_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [SCALAR_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [DATA_W-1:0]   in_src_x,
  input  logic [DATA_W-1:0]   in_src_y,
  input  logic [DATA_W-1:0]   in_src_elev,
  input  logic [DATA_W-1:0]   in_rcv_x,
  input  logic [DATA_W-1:0]   in_rcv_y,
  input  logic [DATA_W-1:0]   in_rcv_elev,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_src_x,
  output logic [DATA_W-1:0]   out_src_y,
  output logic [DATA_W-1:0]   out_src_elev,
  output logic [DATA_W-1:0]   out_rcv_x,
  output logic [DATA_W-1:0]   out_rcv_y,
  output logic [DATA_W-1:0]   out_rcv_elev,
  output logic [DATA_W-1:0]   out_signed_offset
);

  logic [SCALAR_W-1:0] coord_scalar_r, elev_scalar_r;
  logic [SCALAR_W-1:0] coord_div, elev_div;
  coord_t              raw;
  div_word_t           div_head;

  logic       dv_valid [DIV_STEPS+1];
  logic       dv_ready [DIV_STEPS+1];
  div_word_t  dv_data  [DIV_STEPS+1];

  logic       rt_valid [ROOT_STEPS+1];
  logic       rt_ready [ROOT_STEPS+1];
  sqrt_word_t rt_data  [ROOT_STEPS+1];

  logic              out_valid_r, out_ready_int;
  coord_t            out_vals_r;
  logic [DATA_W-1:0] offset_r, offset_nxt;
  sqrt_word_t        last;
  logic              over;

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_scalar_r <= {{(SCALAR_W-1){1'b0}}, 1'b1};
      elev_scalar_r  <= {{(SCALAR_W-1){1'b0}}, 1'b1};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COORD_SCALAR: coord_scalar_r <= cfg_data;
        REG_ELEV_SCALAR:  elev_scalar_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // divisor is the magnitude of a negative scalar, else one
  assign coord_div = coord_scalar_r[SCALAR_W-1] ? (~coord_scalar_r + 1'b1)
                                                : {{(SCALAR_W-1){1'b0}}, 1'b1};
  assign elev_div  = elev_scalar_r[SCALAR_W-1] ? (~elev_scalar_r + 1'b1)
                                               : {{(SCALAR_W-1){1'b0}}, 1'b1};

  // split inputs into sign and magnitude
  always_comb begin
    raw[LANE_SX] = in_src_x;
    raw[LANE_SY] = in_src_y;
    raw[LANE_SE] = in_src_elev;
    raw[LANE_RX] = in_rcv_x;
    raw[LANE_RY] = in_rcv_y;
    raw[LANE_RE] = in_rcv_elev;
    for (int i = 0; i < LANES; i++) begin
      div_head[i].neg = raw[i][DATA_W-1];
      div_head[i].num = raw[i][DATA_W-1] ? (~raw[i] + 1'b1) : raw[i];
      div_head[i].rem = '0;
    end
  end

  assign dv_valid[0] = in_valid;
  assign dv_data[0]  = div_head;
  assign in_ready    = dv_ready[0];

  // division chain
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    tcso_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .coord_div (coord_div),
      .elev_div  (elev_div),
      .in_valid  (dv_valid[k]),
      .in_ready  (dv_ready[k]),
      .in_data   (dv_data[k]),
      .out_valid (dv_valid[k+1]),
      .out_ready (dv_ready[k+1]),
      .out_data  (dv_data[k+1])
    );
  end

  tcso_mid u_mid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid[DIV_STEPS]),
    .in_ready  (dv_ready[DIV_STEPS]),
    .in_data   (dv_data[DIV_STEPS]),
    .out_valid (rt_valid[0]),
    .out_ready (rt_ready[0]),
    .out_data  (rt_data[0])
  );

  // root chain
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    tcso_sqrt_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (rt_valid[k]),
      .in_ready  (rt_ready[k]),
      .in_data   (rt_data[k]),
      .out_valid (rt_valid[k+1]),
      .out_ready (rt_ready[k+1]),
      .out_data  (rt_data[k+1])
    );
  end

  // sign and saturation of the offset
  always_comb begin
    last = rt_data[ROOT_STEPS];
    over = last.sat || (last.res[SUM_W-1:DATA_W-1] != '0);
    if (over) begin
      offset_nxt = last.neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else if (last.neg) begin
      offset_nxt = ~last.res[DATA_W-1:0] + 1'b1;
    end else begin
      offset_nxt = last.res[DATA_W-1:0];
    end
  end

  // output register
  assign out_ready_int        = !out_valid_r || out_ready;
  assign rt_ready[ROOT_STEPS] = out_ready_int;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_r <= rt_valid[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int && rt_valid[ROOT_STEPS]) begin
      out_vals_r <= last.vals;
      offset_r   <= offset_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_src_x         = out_vals_r[LANE_SX];
  assign out_src_y         = out_vals_r[LANE_SY];
  assign out_src_elev      = out_vals_r[LANE_SE];
  assign out_rcv_x         = out_vals_r[LANE_RX];
  assign out_rcv_y         = out_vals_r[LANE_RY];
  assign out_rcv_elev      = out_vals_r[LANE_RE];
  assign out_signed_offset = offset_r;

endmodule

@@ rtl/tcso_checker.sv @@
`include "trace_coordinate_scale_and_offset_top_defines.svh"

module tcso_checker
  import tcso_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_src_x,
  input logic [DATA_W-1:0] out_rcv_x,
  input logic [DATA_W-1:0] out_signed_offset
);

  // a waiting transaction stays put
  `TCSO_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_signed_offset), "output transaction dropped or changed while stalled")

  // empty output register means the whole chain can take input
  `TCSO_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")

  // offset is negative exactly when source x is below receiver x
  `TCSO_ASSERT_NOW(a_offset_neg, clk, rst_n, out_valid && ($signed(out_src_x) < $signed(out_rcv_x)), out_signed_offset[DATA_W-1], "offset not negative")

  `TCSO_ASSERT_NOW(a_offset_pos, clk, rst_n, out_valid && ($signed(out_src_x) >= $signed(out_rcv_x)), !out_signed_offset[DATA_W-1], "offset negative")

endmodule

bind trace_coordinate_scale_and_offset_top tcso_checker u_tcso_checker (.*);
